// ----- src/lrbf_pkg.sv -----
// Shared types, constants and framing helper for the log record block framer.
`default_nettype none
package lrbf_pkg;

  // Block geometry
  localparam int BLOCK_SIZE = 32768;
  localparam int HDR_LEN    = 7;
  localparam int OFS_W      = $clog2(BLOCK_SIZE + 1);
  localparam int LEN_W      = 16;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input opcodes
  localparam logic [1:0] OP_START_SEQ   = 2'd0;
  localparam logic [1:0] OP_START_UNSEQ = 2'd1;
  localparam logic [1:0] OP_PAYLOAD     = 2'd2;

  // Fragment types carried in the header
  localparam logic [7:0] FRAG_FULL   = 8'd1;
  localparam logic [7:0] FRAG_FIRST  = 8'd2;
  localparam logic [7:0] FRAG_MIDDLE = 8'd3;
  localparam logic [7:0] FRAG_LAST   = 8'd4;

  // Header filler in place of a checksum, and pad byte
  localparam logic [7:0] CRC_FILL = 8'h61;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] data_value;
    logic [30:0] seq_number;
    logic [30:0] epoch_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic        eof_flag;
    logic [31:0] file_size;
    logic [30:0] last_sequence;
    logic [30:0] min_sequence;
    logic [30:0] current_epoch;
  } out_item_t;

  // Status snapshot that rides along with each command
  typedef struct packed {
    logic        eof_flag;
    logic [31:0] file_size;
    logic [30:0] last_sequence;
    logic [30:0] min_sequence;
    logic [30:0] current_epoch;
  } stat_t;

  // One classified item: optional payload byte, padding, up to two headers
  typedef struct packed {
    logic             has_byte;
    logic [7:0]       pay_byte;
    logic [2:0]       pad_cnt;
    logic [1:0]       hdr_cnt;
    logic [LEN_W-1:0] len0;
    logic [7:0]       type0;
    logic [LEN_W-1:0] len1;
    logic [7:0]       type1;
    stat_t            stat;
  } cmd_t;

  // Result of opening one fragment
  typedef struct packed {
    logic [2:0]       pad;
    logic [LEN_W-1:0] len;
    logic [7:0]       ftype;
    logic [OFS_W-1:0] off_nxt;
  } frag_plan_t;

  // Back-end sequencer phases
  typedef enum logic [1:0] {
    BK_START,
    BK_BYTE,
    BK_PAD,
    BK_HDR
  } bk_phase_t;

  // Pad the block tail if a header no longer fits, then open one fragment
  function automatic frag_plan_t open_frag(input logic [OFS_W-1:0] off,
                                           input logic [23:0] rec,
                                           input logic first_f);
    frag_plan_t       p;
    logic [OFS_W-1:0] leftover;
    logic [OFS_W-1:0] off0;
    logic [OFS_W-1:0] avail;
    logic             last_f;
    leftover = (off > OFS_W'(BLOCK_SIZE)) ? '0 : (OFS_W'(BLOCK_SIZE) - off);
    if (leftover < OFS_W'(HDR_LEN)) begin
      p.pad = 3'(leftover);
      off0  = '0;
    end else begin
      p.pad = 3'd0;
      off0  = off;
    end
    avail  = OFS_W'(BLOCK_SIZE - HDR_LEN) - off0;
    p.len  = (32'(rec) < 32'(avail)) ? LEN_W'(rec) : LEN_W'(avail);
    last_f = (32'(rec) == 32'(p.len));
    if (first_f && last_f) p.ftype = FRAG_FULL;
    else if (first_f)      p.ftype = FRAG_FIRST;
    else if (last_f)       p.ftype = FRAG_LAST;
    else                   p.ftype = FRAG_MIDDLE;
    p.off_nxt = off0 + OFS_W'(HDR_LEN);
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- src/lrbf_front.sv -----
// Front end: accepts items, keeps framing and status state, emits commands.
`default_nettype none
module lrbf_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire lrbf_pkg::in_item_t in_item,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output lrbf_pkg::cmd_t          q_cmd
);

  logic [31:0]                 max_log_size_r;
  logic [lrbf_pkg::OFS_W-1:0]  off_r, off_nxt;
  logic [23:0]                 rec_r, rec_nxt;
  logic [lrbf_pkg::LEN_W-1:0]  frag_r, frag_nxt;
  logic [31:0]                 total_r, total_nxt;
  logic                        eof_r, eof_nxt;
  logic                        min_seen_r, min_seen_nxt;
  logic [30:0]                 min_seq_r, min_seq_nxt;
  logic [30:0]                 last_seq_r, last_seq_nxt;
  logic [30:0]                 epoch_r, epoch_nxt;

  logic                        accept;
  logic                        is_start;
  logic                        is_pay;
  logic [32:0]                 sum;
  logic [lrbf_pkg::OFS_W-1:0]  off_a;
  logic [23:0]                 rec_a;
  logic [lrbf_pkg::LEN_W-1:0]  frag_a;
  logic [lrbf_pkg::OFS_W-1:0]  base_off;
  logic [23:0]                 base_rec;
  logic                        open_f;
  logic                        need2;
  lrbf_pkg::frag_plan_t        p0, p1;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_item.opcode == lrbf_pkg::OP_START_SEQ) ||
                    (in_item.opcode == lrbf_pkg::OP_START_UNSEQ);
  assign is_pay   = (in_item.opcode == lrbf_pkg::OP_PAYLOAD) &&
                    (rec_r != '0) && (frag_r != '0);

  // Payload byte advance
  assign off_a  = off_r + lrbf_pkg::OFS_W'(1);
  assign rec_a  = rec_r - 24'd1;
  assign frag_a = frag_r - lrbf_pkg::LEN_W'(1);

  // Fragment opening: a start always opens, a payload byte at a fragment end does
  assign base_off = is_start ? off_r : off_a;
  assign base_rec = is_start ? in_item.data_value : rec_a;
  assign open_f   = is_start || ((frag_a == '0) && (rec_a != '0));
  assign p0       = lrbf_pkg::open_frag(base_off, base_rec, is_start);
  assign need2    = (p0.len == '0) && (base_rec != '0);
  assign p1       = lrbf_pkg::open_frag(p0.off_nxt, base_rec, 1'b0);

  // Saturating file size
  assign sum = {1'b0, total_r} + 33'(in_item.data_value);

  // Next-state logic
  always_comb begin
    off_nxt      = off_r;
    rec_nxt      = rec_r;
    frag_nxt     = frag_r;
    total_nxt    = total_r;
    eof_nxt      = eof_r;
    min_seen_nxt = min_seen_r;
    min_seq_nxt  = min_seq_r;
    last_seq_nxt = last_seq_r;
    epoch_nxt    = epoch_r;
    if (is_start) begin
      total_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      eof_nxt   = eof_r || (total_nxt >= max_log_size_r);
      if (in_item.opcode == lrbf_pkg::OP_START_SEQ) begin
        if (!min_seen_r) begin
          min_seen_nxt = 1'b1;
          min_seq_nxt  = in_item.seq_number;
        end
        last_seq_nxt = in_item.seq_number;
        epoch_nxt    = in_item.epoch_number;
      end
      rec_nxt  = in_item.data_value;
      off_nxt  = need2 ? p1.off_nxt : p0.off_nxt;
      frag_nxt = need2 ? p1.len : p0.len;
    end else if (is_pay) begin
      rec_nxt = rec_a;
      if (open_f) begin
        off_nxt  = need2 ? p1.off_nxt : p0.off_nxt;
        frag_nxt = need2 ? p1.len : p0.len;
      end else begin
        off_nxt  = off_a;
        frag_nxt = frag_a;
      end
    end
  end

  // Command build
  always_comb begin
    q_push                   = accept && (is_start || is_pay);
    q_cmd.has_byte           = !is_start;
    q_cmd.pay_byte           = in_item.data_value[7:0];
    q_cmd.pad_cnt            = open_f ? p0.pad : 3'd0;
    q_cmd.hdr_cnt            = !open_f ? 2'd0 : (need2 ? 2'd2 : 2'd1);
    q_cmd.len0               = p0.len;
    q_cmd.type0              = p0.ftype;
    q_cmd.len1               = p1.len;
    q_cmd.type1              = p1.ftype;
    q_cmd.stat.eof_flag      = eof_nxt;
    q_cmd.stat.file_size     = total_nxt;
    q_cmd.stat.last_sequence = last_seq_nxt;
    q_cmd.stat.min_sequence  = min_seq_nxt;
    q_cmd.stat.current_epoch = epoch_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_log_size_r <= 32'd67108864;
      off_r          <= '0;
      rec_r          <= '0;
      frag_r         <= '0;
      total_r        <= '0;
      eof_r          <= 1'b0;
      min_seen_r     <= 1'b0;
      min_seq_r      <= '0;
      last_seq_r     <= '0;
      epoch_r        <= '0;
    end else begin
      if (cfg_wr_en) max_log_size_r <= cfg_wr_data;
      if (accept) begin
        off_r      <= off_nxt;
        rec_r      <= rec_nxt;
        frag_r     <= frag_nxt;
        total_r    <= total_nxt;
        eof_r      <= eof_nxt;
        min_seen_r <= min_seen_nxt;
        min_seq_r  <= min_seq_nxt;
        last_seq_r <= last_seq_nxt;
        epoch_r    <= epoch_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/lrbf_cmd_fifo.sv -----
// Small command queue between the front and back ends.
`default_nettype none
module lrbf_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire lrbf_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output lrbf_pkg::cmd_t      head_cmd
);

  lrbf_pkg::cmd_t              ent_r [lrbf_pkg::QDEPTH];
  logic [lrbf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lrbf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lrbf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (cnt_r == lrbf_pkg::QCNT_W'(lrbf_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lrbf_pkg::QPTR_W'(lrbf_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + lrbf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lrbf_pkg::QPTR_W'(lrbf_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + lrbf_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop)      cnt_nxt = cnt_r + lrbf_pkg::QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - lrbf_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_ptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

// ----- src/lrbf_back.sv -----
// Back end: expands queued commands into the output byte stream.
`default_nettype none
module lrbf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire lrbf_pkg::cmd_t      head_cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lrbf_pkg::out_item_t      out_item
);

  lrbf_pkg::bk_phase_t phase_r, phase_nxt;
  lrbf_pkg::bk_phase_t eff;
  logic [2:0]          cnt_r, cnt_nxt;
  logic                sel_r, sel_nxt;
  logic                out_valid_r;
  lrbf_pkg::out_item_t out_item_r;
  logic                emit;
  logic                finish;
  logic [7:0]          byte_v;
  logic [lrbf_pkg::LEN_W-1:0] hlen;
  logic [7:0]          htype;

  assign emit  = head_valid && (!out_valid_r || out_ready);
  assign hlen  = sel_r ? head_cmd.len1 : head_cmd.len0;
  assign htype = sel_r ? head_cmd.type1 : head_cmd.type0;

  // Sequencer: next phase and byte selection
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    finish    = 1'b0;
    byte_v    = lrbf_pkg::PAD_BYTE;
    eff       = phase_r;
    if (phase_r == lrbf_pkg::BK_START) begin
      if (head_cmd.has_byte)            eff = lrbf_pkg::BK_BYTE;
      else if (head_cmd.pad_cnt != '0)  eff = lrbf_pkg::BK_PAD;
      else                              eff = lrbf_pkg::BK_HDR;
    end
    unique case (eff)
      lrbf_pkg::BK_BYTE: begin
        byte_v = head_cmd.pay_byte;
        cnt_nxt = 3'd0;
        sel_nxt = 1'b0;
        if (head_cmd.pad_cnt != '0)      phase_nxt = lrbf_pkg::BK_PAD;
        else if (head_cmd.hdr_cnt != '0) phase_nxt = lrbf_pkg::BK_HDR;
        else                             finish = 1'b1;
      end
      lrbf_pkg::BK_PAD: begin
        byte_v = lrbf_pkg::PAD_BYTE;
        if (cnt_r == head_cmd.pad_cnt - 3'd1) begin
          cnt_nxt = 3'd0;
          sel_nxt = 1'b0;
          if (head_cmd.hdr_cnt != '0) phase_nxt = lrbf_pkg::BK_HDR;
          else                        finish = 1'b1;
        end else begin
          phase_nxt = lrbf_pkg::BK_PAD;
          cnt_nxt   = cnt_r + 3'd1;
        end
      end
      lrbf_pkg::BK_HDR: begin
        unique case (cnt_r)
          3'd4:    byte_v = hlen[7:0];
          3'd5:    byte_v = hlen[15:8];
          3'd6:    byte_v = htype;
          default: byte_v = lrbf_pkg::CRC_FILL;
        endcase
        phase_nxt = lrbf_pkg::BK_HDR;
        if (cnt_r == 3'(lrbf_pkg::HDR_LEN - 1)) begin
          cnt_nxt = 3'd0;
          if (!sel_r && (head_cmd.hdr_cnt == 2'd2)) sel_nxt = 1'b1;
          else                                      finish = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      default: begin
        byte_v = lrbf_pkg::PAD_BYTE;
      end
    endcase
    if (finish) begin
      phase_nxt = lrbf_pkg::BK_START;
      cnt_nxt   = 3'd0;
      sel_nxt   = 1'b0;
    end
  end

  assign pop = emit && finish;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lrbf_pkg::BK_START;
      cnt_r   <= 3'd0;
      sel_r   <= 1'b0;
    end else if (emit) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.out_byte      <= byte_v;
      out_item_r.out_last      <= finish;
      out_item_r.eof_flag      <= head_cmd.stat.eof_flag;
      out_item_r.file_size     <= head_cmd.stat.file_size;
      out_item_r.last_sequence <= head_cmd.stat.last_sequence;
      out_item_r.min_sequence  <= head_cmd.stat.min_sequence;
      out_item_r.current_epoch <= head_cmd.stat.current_epoch;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// ----- src/log_record_block_framer.sv -----
// Top level of the log record block framer.
//
//   channel  ports                              payload
//   in       in_valid / in_ready                in_item   (lrbf_pkg::in_item_t)
//   out      out_valid / out_ready              out_item  (lrbf_pkg::out_item_t)
//   cfg      cfg_wr_en (no wait)                cfg_wr_data (max_log_size)
//
// Each output transfer carries one byte, so payload streams at one item per clock
// while out_ready is high and no header is due; a byte that closes a fragment
// mid-record adds any block padding and the next 7-byte header (or two). A start
// item emits padding plus one or two headers, and no payload byte.
// A 4-entry command queue lets the front keep accepting while the back drains.
// rst_n is synchronous, active low; out_ready low holds the output register.
`default_nettype none
module log_record_block_framer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lrbf_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lrbf_pkg::out_item_t      out_item,
  input  wire logic                cfg_wr_en,
  input  wire logic [31:0]         cfg_wr_data
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_head_valid;
  lrbf_pkg::cmd_t q_push_cmd;
  lrbf_pkg::cmd_t q_head_cmd;

  lrbf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_push_cmd)
  );

  lrbf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  lrbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire
